// ----- src/u8u16_pkg.sv -----
package u8u16_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // one queued job: an optional code unit, then an optional terminator
    typedef struct packed {
        logic [15:0] unit;
        logic        has_unit;
        logic        has_term;
        logic [15:0] count;
        logic        ovf;
    } entry_t;

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_UNIT,
        ST_TERM
    } back_state_t;

endpackage

// ----- src/u8u16_in_if.sv -----
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

// ----- src/u8u16_out_if.sv -----
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_terminator;
    logic [15:0] unit_count;
    logic        overflow;
    logic        last_of_run;

    modport source (output valid, output code_unit, output is_terminator,
                    output unit_count, output overflow, output last_of_run,
                    input ready);
    modport sink (input valid, input code_unit, input is_terminator,
                  input unit_count, input overflow, input last_of_run,
                  output ready);
endinterface

// ----- src/u8u16_cfg_if.sv -----
interface u8u16_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit_capacity;

    modport source (output valid, output unit_capacity, input ready);
    modport sink (input valid, input unit_capacity, output ready);
endinterface

// ----- src/u8u16_front.sv -----
module u8u16_front (
    input  logic              clk,
    input  logic              rst_n,
    u8u16_in_if.sink          in_item,
    u8u16_cfg_if.sink         cfg,
    input  logic              q_full,
    output logic              push,
    output u8u16_pkg::entry_t entry
);

    logic [15:0] cap_reg;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [15:0] stored_reg;
    logic [15:0] stored_next;
    logic        ended_reg;
    logic        ended_next;

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] limit;
    logic [15:0] acc_upd;
    logic [15:0] unit;
    logic        have;
    logic        stop;
    logic        ovf;

    assign cfg.ready     = 1'b1;
    assign in_item.ready = !q_full;
    assign accept        = in_item.valid && in_item.ready;
    assign b             = in_item.byte_in;
    assign fin           = in_item.final_byte;
    // capacity zero wraps to the full 16-bit range
    assign limit         = cap_reg - 16'd1;

    always_comb
    begin
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        stored_next = stored_reg;
        ended_next  = ended_reg;
        acc_upd     = {acc_reg[9:0], b[5:0]};
        unit        = 16'd0;
        have        = 1'b0;
        stop        = 1'b0;
        ovf         = 1'b0;
        entry       = '0;
        push        = 1'b0;
        if (accept)
        begin
            if (ended_reg)
            begin
                // discard up to the last byte of the buffer
                if (fin)
                begin
                    ended_next  = 1'b0;
                    stored_next = 16'd0;
                    pend_next   = 2'd0;
                    acc_next    = 16'd0;
                end
            end
            else
            begin
                if (pend_reg != 2'd0)
                begin
                    acc_next  = acc_upd;
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        have = 1'b1;
                        unit = acc_upd;
                    end
                end
                else if (b == u8u16_pkg::CHAR_NUL)
                begin
                    stop = 1'b1;
                end
                else if (b == u8u16_pkg::CHAR_CR || b == u8u16_pkg::CHAR_LF ||
                         (!b[7] && b[6:5] != 2'b00))
                begin
                    have = 1'b1;
                    unit = {8'h00, b};
                end
                else if (b[7:4] == 4'hE)
                begin
                    acc_next  = {12'h000, b[3:0]};
                    pend_next = 2'd2;
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc_next  = {11'h000, b[4:0]};
                    pend_next = 2'd1;
                end

                if (have)
                begin
                    if (stored_reg == limit)
                    begin
                        stop = 1'b1;
                        ovf  = 1'b1;
                    end
                    else
                    begin
                        entry.unit     = unit;
                        entry.has_unit = 1'b1;
                        stored_next    = stored_reg + 16'd1;
                    end
                end

                if (fin)
                begin
                    stop = 1'b1;
                end

                if (stop)
                begin
                    entry.has_term = 1'b1;
                    entry.count    = stored_next;
                    entry.ovf      = ovf;
                    pend_next      = 2'd0;
                    acc_next       = 16'd0;
                    if (fin)
                    begin
                        stored_next = 16'd0;
                        ended_next  = 1'b0;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end

                push = entry.has_unit || entry.has_term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= u8u16_pkg::CAP_RESET;
            pend_reg   <= 2'd0;
            acc_reg    <= 16'd0;
            stored_reg <= 16'd0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.unit_capacity;
            end
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            stored_reg <= stored_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// ----- src/u8u16_queue.sv -----
module u8u16_queue #(
    parameter int unsigned Depth = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8u16_pkg::entry_t wr_entry,
    input  logic              pop,
    output u8u16_pkg::entry_t head,
    output logic              full,
    output logic              empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    u8u16_pkg::entry_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/u8u16_back.sv -----
module u8u16_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u8u16_pkg::entry_t head,
    input  logic              q_empty,
    output logic              pop,
    u8u16_out_if.source       out_item
);

    u8u16_pkg::back_state_t state_reg;
    u8u16_pkg::back_state_t state_next;
    u8u16_pkg::entry_t      cur_reg;
    logic                   take;

    always_comb
    begin
        state_next             = state_reg;
        take                   = 1'b0;
        out_item.valid         = 1'b0;
        out_item.code_unit     = 16'd0;
        out_item.is_terminator = 1'b0;
        out_item.unit_count    = 16'd0;
        out_item.overflow      = 1'b0;
        out_item.last_of_run   = 1'b0;
        case (state_reg)
            u8u16_pkg::ST_EMPTY:
            begin
                take = 1'b1;
            end
            u8u16_pkg::ST_UNIT:
            begin
                out_item.valid       = 1'b1;
                out_item.code_unit   = cur_reg.unit;
                out_item.last_of_run = !cur_reg.has_term;
                if (out_item.ready)
                begin
                    if (cur_reg.has_term)
                    begin
                        state_next = u8u16_pkg::ST_TERM;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
            end
            u8u16_pkg::ST_TERM:
            begin
                out_item.valid         = 1'b1;
                out_item.is_terminator = 1'b1;
                out_item.unit_count    = cur_reg.count;
                out_item.overflow      = cur_reg.ovf;
                out_item.last_of_run   = 1'b1;
                take                   = out_item.ready;
            end
            default:
            begin
                state_next = u8u16_pkg::ST_EMPTY;
            end
        endcase

        // refill the output register straight from the queue head
        pop = take && !q_empty;
        if (take)
        begin
            if (q_empty)
            begin
                state_next = u8u16_pkg::ST_EMPTY;
            end
            else if (head.has_unit)
            begin
                state_next = u8u16_pkg::ST_UNIT;
            end
            else
            begin
                state_next = u8u16_pkg::ST_TERM;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= u8u16_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/utf8_to_utf16_filtering_decoder_core.sv -----
// channel   dir   payload                                         handshake
// in_item   in    byte_in, final_byte                             valid/ready
// out_item  out   code_unit, is_terminator, unit_count,           valid/ready
//                 overflow, last_of_run
// cfg       in    unit_capacity                                   valid/ready
//
// one byte a cycle is accepted while the queue has room; a byte is decoded in its
// accept cycle and its results pass through the queue and then the output register
// a byte that ends with a unit and a terminator holds the output for both results in
// turn; the queue absorbs that and output stalls up to QueueDepth entries
// rst_n clears decoder state, the queue and the output stage; capacity resets to 256
// cfg is always ready and takes effect on the next accepted byte
module utf8_to_utf16_filtering_decoder_core #(
    parameter int unsigned QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    u8u16_in_if.sink    in_item,
    u8u16_out_if.source out_item,
    u8u16_cfg_if.sink   cfg
);

    u8u16_pkg::entry_t wr_entry;
    u8u16_pkg::entry_t head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    u8u16_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cfg     (cfg),
        .q_full  (q_full),
        .push    (push),
        .entry   (wr_entry)
    );

    u8u16_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    u8u16_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .out_item (out_item)
    );

`ifndef SYNTH
    // a unit that is not last of its byte is followed by that byte's terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && out_item.ready && !out_item.last_of_run
        |=> out_item.valid && out_item.is_terminator)
        else $error("unit result not followed by terminator");

    // count and overflow only travel with a terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.is_terminator
        |-> out_item.unit_count == 16'd0 && !out_item.overflow)
        else $error("unit result carries terminator fields");

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    // the back only pops when it has room for a new entry
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty && (!out_item.valid || out_item.ready))
        else $error("pop while output stalled");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 1450;

    localparam logic [7:0] PRINT_FIRST = 8'h20;
    localparam logic [7:0] PRINT_LAST  = 8'h7F;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_terminator;
        logic [15:0] unit_count;
        logic        overflow;
        logic        last_of_run;
    } unit_result_t;

    logic clk;
    logic rst_n;

    u8u16_in_if  in_ch ();
    u8u16_out_if out_ch ();
    u8u16_cfg_if cfg_ch ();

    utf8_to_utf16_filtering_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch),
        .cfg      (cfg_ch)
    );

    // decoder model state
    logic [15:0] model_capacity = u8u16_pkg::CAP_RESET;
    logic [1:0]  model_pending  = '0;
    logic [15:0] model_accum    = '0;
    logic [15:0] model_stored   = '0;
    logic        model_discard  = 1'b0;

    unit_result_t expected_units[$];
    unit_result_t head;
    logic [7:0]   src_bytes[$];

    int mismatches    = 0;
    int bytes_sent    = 0;
    int idle_cycles   = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void decode_utf8_byte(logic [7:0] b, logic fin);
        unit_result_t res[2];
        int           n;
        logic         have;
        logic         stop;
        logic         ovf;
        logic [15:0]  unit_val;
        n = 0;
        have = 1'b0;
        stop = 1'b0;
        ovf = 1'b0;
        unit_val = '0;
        // after an early end, bytes are dropped up to the last one of the buffer
        if (model_discard)
        begin
            if (fin)
            begin
                model_discard = 1'b0;
                model_stored = '0;
                model_pending = '0;
                model_accum = '0;
            end
            return;
        end
        if (model_pending != 0)
        begin
            // any byte counts as a continuation, only its low six bits are kept
            model_accum = {model_accum[9:0], b[5:0]};
            model_pending = model_pending - 2'd1;
            if (model_pending == 0)
            begin
                have = 1'b1;
                unit_val = model_accum;
            end
        end
        else if (b == u8u16_pkg::CHAR_NUL)
            stop = 1'b1;
        else if (b == u8u16_pkg::CHAR_CR || b == u8u16_pkg::CHAR_LF ||
                 (b >= PRINT_FIRST && b <= PRINT_LAST))
        begin
            have = 1'b1;
            unit_val = {8'h00, b};
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
        begin
            model_accum = {12'h000, b[3:0]};
            model_pending = 2'd2;
        end
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
        begin
            model_accum = {11'h000, b[4:0]};
            model_pending = 2'd1;
        end
        if (have)
        begin
            // capacity zero wraps to a limit of 65535
            if (model_stored == model_capacity - 16'd1)
            begin
                stop = 1'b1;
                ovf = 1'b1;
            end
            else
            begin
                res[n] = '{unit_val, 1'b0, 16'd0, 1'b0, 1'b0};
                n++;
                model_stored = model_stored + 16'd1;
            end
        end
        if (fin)
            stop = 1'b1;
        if (stop)
        begin
            res[n] = '{16'd0, 1'b1, model_stored, ovf, 1'b0};
            n++;
            model_pending = '0;
            model_accum = '0;
            if (fin)
                model_stored = '0;
            model_discard = !fin;
        end
        if (n > 0)
            res[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_units.push_back(res[i]);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_units.size() == 0)
                begin
                    $error("unexpected item: code_unit %h, is_terminator %b",
                           out_ch.code_unit, out_ch.is_terminator);
                    mismatches++;
                end
                else
                begin
                    head = expected_units.pop_front();
                    if (out_ch.code_unit !== head.code_unit)
                    begin
                        $error("code_unit: expected %h, got %h",
                               head.code_unit, out_ch.code_unit);
                        mismatches++;
                    end
                    if (out_ch.is_terminator !== head.is_terminator)
                    begin
                        $error("is_terminator: expected %b, got %b",
                               head.is_terminator, out_ch.is_terminator);
                        mismatches++;
                    end
                    if (out_ch.unit_count !== head.unit_count)
                    begin
                        $error("unit_count: expected %0d, got %0d",
                               head.unit_count, out_ch.unit_count);
                        mismatches++;
                    end
                    if (out_ch.overflow !== head.overflow)
                    begin
                        $error("overflow: expected %b, got %b",
                               head.overflow, out_ch.overflow);
                        mismatches++;
                    end
                    if (out_ch.last_of_run !== head.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               head.last_of_run, out_ch.last_of_run);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                decode_utf8_byte(in_ch.byte_in, in_ch.final_byte);
            if (cfg_ch.valid && cfg_ch.ready)
                model_capacity = cfg_ch.unit_capacity;

            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.byte_in <= b;
        in_ch.final_byte <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (src_bytes[i])
            send_byte(src_bytes[i], i == src_bytes.size() - 1);
    endtask

    // let every expected item arrive, then give the block time to go quiet
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.unit_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly well-formed text; the length cut may split a sequence
    task automatic build_buffer(input int len, input int noise_pct);
        src_bytes.delete();
        while (src_bytes.size() < len)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                if ($urandom_range(15) == 0)
                    src_bytes.push_back(u8u16_pkg::CHAR_NUL);
                else
                    src_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                case ($urandom_range(5))
                    0: src_bytes.push_back($urandom_range(1) ? u8u16_pkg::CHAR_CR
                                                              : u8u16_pkg::CHAR_LF);
                    1, 2: src_bytes.push_back(8'($urandom_range(PRINT_LAST, PRINT_FIRST)));
                    3:
                    begin
                        src_bytes.push_back(LEAD2_TAG | 8'($urandom_range(31)));
                        src_bytes.push_back(CONT_TAG | 8'($urandom_range(63)));
                    end
                    default:
                    begin
                        src_bytes.push_back(LEAD3_TAG | 8'($urandom_range(15)));
                        src_bytes.push_back(CONT_TAG | 8'($urandom_range(63)));
                        src_bytes.push_back(CONT_TAG | 8'($urandom_range(63)));
                    end
                endcase
            end
        end
        while (src_bytes.size() > len)
            void'(src_bytes.pop_back());
    endtask

    task automatic test_directed();
        // printable bounds, cr, lf, two and three byte sequences, skipped bytes
        src_bytes = '{PRINT_FIRST, PRINT_LAST, u8u16_pkg::CHAR_CR, u8u16_pkg::CHAR_LF,
                      8'hC3, 8'hA9, 8'hDF, 8'hBF,
                      8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF, 8'h01, 8'h80, 8'hFF,
                      8'hF0, 8'h41};
        send_buffer();
        // nul taken as a continuation, then nul ends the buffer early
        src_bytes = '{8'hC3, u8u16_pkg::CHAR_NUL, u8u16_pkg::CHAR_NUL, 8'h78, 8'h79};
        send_buffer();
        // three byte sequence cut short by the last byte
        src_bytes = '{8'hE2, 8'h82};
        send_buffer();
    endtask

    task automatic test_capacity();
        write_capacity(16'd1);
        // very first unit hits the limit
        src_bytes = '{8'h61, 8'h62, 8'h63};
        send_buffer();
        src_bytes = '{8'h64};
        send_buffer();
        write_capacity(16'd3);
        repeat (3)
        begin
            build_buffer(10, 0);
            send_buffer();
        end
        write_capacity(16'd0);
        build_buffer(12, 10);
        send_buffer();
        write_capacity(16'd65535);
        build_buffer(12, 10);
        send_buffer();
    endtask

    task automatic test_random();
        int   goal;
        logic paused;
        paused = 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_capacity(16'($urandom_range(12, 2)));
                1: write_capacity(u8u16_pkg::CAP_RESET);
                2: write_capacity(16'($urandom_range(40, 2)));
                default: write_capacity(16'($urandom_range(6, 1)));
            endcase
            in_idle_pct = (phase == 1) ? 47 : (phase == 3) ? 19 : 0;
            out_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 19 : 0;
            goal = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < goal)
            begin
                build_buffer($urandom_range(24, 1), 15);
                send_buffer();
                // hold the sender once until the output side has caught up
                if (phase == 1 && !paused && bytes_sent > goal - RANDOM_BYTES / 8)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.byte_in = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.unit_capacity = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_random();

        wait_drained();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
